// ===== design/ljep_pkg.sv =====
// ljep_pkg: shared constants, link type and arithmetic helpers for the
// layered Julia escape-time pixel core. No dependencies.

package ljep_pkg;

  localparam int LAYERS    = 8;
  localparam int FRAC_BITS = 12;
  localparam int LAYER_W   = $clog2(LAYERS);
  localparam int NUM_CELLS = 2 * (LAYERS - 1);
  localparam int CNT_W     = 4;
  localparam int CHAIN_W   = $clog2(NUM_CELLS + 1);
  localparam int NUM_CFG   = LAYERS - 1;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [63:0] ESC_LIMIT = 64'sd4 <<< (2 * FRAC_BITS);

  // products of one orbit point plus escape bookkeeping
  typedef struct packed {
    logic [31:0]      xx;
    logic [31:0]      yy;
    logic [31:0]      xy;
    logic             hit;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] k;
  } ljep_link_t;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

  function automatic logic esc_hit(input logic [31:0] xx, input logic [31:0] yy);
    logic [31:0] mag;
    mag = xx + yy;
    return $signed({{32{mag[31]}}, mag}) > ESC_LIMIT;
  endfunction

endpackage

// ===== design/ljep_cell.sv =====
// ljep_cell: one Julia iteration stage of the chain; takes the registered
// squares/cross product of z, forms z^2 + c and registers its products.
// Depends on ljep_pkg.

module ljep_cell import ljep_pkg::*; (
  input  logic       clk,
  input  ljep_link_t link_i,
  input  logic [15:0] c_re,
  input  logic [15:0] c_im,
  output ljep_link_t link_o
);

  logic [31:0] dif;
  logic [31:0] x1;
  logic [31:0] y1;
  logic        esc_now;
  ljep_link_t  link_nxt;
  ljep_link_t  link_r;

  always_comb begin
    dif = link_i.xx - link_i.yy;
    x1  = 32'($signed(dif) >>> FRAC_BITS) + {{16{c_re[15]}}, c_re};
    y1  = 32'($signed(link_i.xy) >>> (FRAC_BITS - 1)) + {{16{c_im[15]}}, c_im};
    // incoming products are the magnitude of the previous iteration
    esc_now = (link_i.k != '0) && !link_i.hit && esc_hit(link_i.xx, link_i.yy);
    link_nxt.xx  = mul32(x1, x1);
    link_nxt.yy  = mul32(y1, y1);
    link_nxt.xy  = mul32(x1, y1);
    link_nxt.hit = link_i.hit | esc_now;
    link_nxt.cnt = esc_now ? link_i.k - 1'b1 : link_i.cnt;
    link_nxt.k   = link_i.k + 1'b1;
  end

  always_ff @(posedge clk) begin
    link_r <= link_nxt;
  end

  assign link_o = link_r;

endmodule

// ===== design/layered_julia_escape_pixel_core.sv =====
// layered_julia_escape_pixel_core: top level; config registers, layer
// sequencer, entry stage and the chain of ljep_cell iteration stages.
// Depends on ljep_pkg and ljep_cell.
//
// Usage: write the seven layer constants through cfg_we/cfg_idx/cfg_wdata
// while idle (index i holds layer i+1, re in bits 15..0, im in 31..16).
// An item is taken when start is high and busy is low. The point and start
// layer are captured; layers are then tried from the start layer down to 1.
// Each layer runs its 2L iterations through a chain of iteration cells, one
// cell per cycle, after the entry stage; a layer that escapes ends the
// item, else the next lower layer follows. The result is registered and
// shown on out_escape_layer/out_escape_count with out_valid high for one
// cycle. Start layer 0 returns the zero result in the cycle after start.
// One item is in flight at a time; busy drops in the result cycle, so the
// next start can be taken then. The receiver cannot stall the result.
// Reset clears the constants, drops busy and out_valid.

module layered_julia_escape_pixel_core import ljep_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [15:0]   in_point_re,
  input  logic signed [15:0]   in_point_im,
  input  logic [2:0]           in_start_layer,
  output logic                 out_valid,
  output logic [2:0]           out_escape_layer,
  output logic [3:0]           out_escape_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_wdata
);

  typedef enum logic [0:0] {S_IDLE, S_RUN} state_t;

  state_t             state_r, state_nxt;
  logic [LAYER_W-1:0] layer_r, layer_nxt;
  logic [CNT_W-1:0]   t_r, t_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         esc_layer_r, esc_layer_nxt;
  logic [CNT_W-1:0]   esc_cnt_r, esc_cnt_nxt;

  logic [31:0]        c_r [NUM_CFG];
  logic [31:0]        c_cur_r, c_cur_nxt;
  logic [15:0]        pre_r, pim_r;

  ljep_link_t         entry_r, entry_nxt;
  ljep_link_t         chain [NUM_CELLS+1];

  logic [2:0]         sat_start;
  logic [LAYER_W-1:0] shift;
  logic [15:0]        ent_re, ent_im;
  logic [31:0]        sx, sy;
  logic [CNT_W-1:0]   two_l;
  ljep_link_t         tap;
  logic               layer_esc;
  logic [CNT_W-1:0]   layer_cnt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) c_r[i] <= '0;
    end else if (cfg_we && (32'(cfg_idx) < NUM_CFG)) begin
      c_r[cfg_idx] <= cfg_wdata;
    end
  end

  assign sat_start = (in_start_layer > 3'(LAYERS - 1)) ? 3'(LAYERS - 1) : in_start_layer;
  assign two_l     = CNT_W'({layer_r, 1'b0});
  assign tap       = chain[CHAIN_W'({layer_r, 1'b0})];
  assign layer_esc = tap.hit || esc_hit(tap.xx, tap.yy);
  assign layer_cnt = tap.hit ? tap.cnt : tap.k - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    layer_nxt     = layer_r;
    t_nxt         = t_r + 1'b1;
    out_valid_nxt = 1'b0;
    esc_layer_nxt = esc_layer_r;
    esc_cnt_nxt   = esc_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (sat_start == '0) begin
            out_valid_nxt = 1'b1;
            esc_layer_nxt = '0;
            esc_cnt_nxt   = '0;
          end else begin
            state_nxt = S_RUN;
            layer_nxt = LAYER_W'(sat_start);
            t_nxt     = '0;
          end
        end
      end
      S_RUN: begin
        if (t_r == two_l) begin
          if (layer_esc) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            esc_layer_nxt = 3'(layer_r);
            esc_cnt_nxt   = layer_cnt;
          end else if (layer_r == LAYER_W'(1)) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            esc_layer_nxt = '0;
            esc_cnt_nxt   = '0;
          end else begin
            layer_nxt = layer_r - 1'b1;
            t_nxt     = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      layer_r     <= '0;
      t_r         <= '0;
      out_valid_r <= 1'b0;
      esc_layer_r <= '0;
      esc_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      layer_r     <= layer_nxt;
      t_r         <= t_nxt;
      out_valid_r <= out_valid_nxt;
      esc_layer_r <= esc_layer_nxt;
      esc_cnt_r   <= esc_cnt_nxt;
    end
  end

  // entry stage: products of the shifted start point for the layer in line
  always_comb begin
    ent_re    = (state_r == S_IDLE) ? in_point_re : pre_r;
    ent_im    = (state_r == S_IDLE) ? in_point_im : pim_r;
    shift     = LAYER_W'(LAYERS - 1) - layer_nxt;
    sx        = {{16{ent_re[15]}}, ent_re} << shift;
    sy        = {{16{ent_im[15]}}, ent_im} << shift;
    entry_nxt.xx  = mul32(sx, sx);
    entry_nxt.yy  = mul32(sy, sy);
    entry_nxt.xy  = mul32(sx, sy);
    entry_nxt.hit = 1'b0;
    entry_nxt.cnt = '0;
    entry_nxt.k   = '0;
    c_cur_nxt = (layer_nxt != '0) ? c_r[CFG_IDX_W'(layer_nxt - 1'b1)] : '0;
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    c_cur_r <= c_cur_nxt;
    if (start && !busy) begin
      pre_r <= in_point_re;
      pim_r <= in_point_im;
    end
  end

  assign chain[0] = entry_r;

  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    ljep_cell u_cell (
      .clk    (clk),
      .link_i (chain[j]),
      .c_re   (c_cur_r[15:0]),
      .c_im   (c_cur_r[31:16]),
      .link_o (chain[j+1])
    );
  end

  assign busy             = (state_r == S_RUN);
  assign out_valid        = out_valid_r;
  assign out_escape_layer = esc_layer_r;
  assign out_escape_count = esc_cnt_r;

  a_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_start_layer == 3'd0) |=> (out_valid && out_escape_layer == 3'd0))
    else $error("start layer zero did not give an immediate zero result");

  a_t_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (t_r <= two_l && layer_r != '0))
    else $error("iteration counter ran past the layer length");

  a_zero_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_escape_layer == 3'd0) |-> out_escape_count == 4'd0)
    else $error("non-escape result carries a count");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_escape_layer != 3'd0) |->
      ({1'b0, out_escape_count} < {1'b0, out_escape_layer, 1'b0}))
    else $error("escape count beyond the layer's iterations");

  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(busy)) |-> !busy)
    else $error("result shown while still running");

endmodule

// ===== test/layered_julia_escape_pixel_core_test.sv =====
// Self-checking testbench for layered_julia_escape_pixel_core: predicts the
// escape layer and count of each point and checks every result item.
// Depends on ljep_pkg and the core RTL.

module layered_julia_escape_pixel_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ljep_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    C_LAYER1, C_LAYER2, C_LAYER3, C_LAYER4, C_LAYER5, C_LAYER6, C_LAYER7, C_SPARE
  } layer_reg_t;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [2:0]         layer;
  } pixel_t;

  typedef struct {
    logic [2:0] layer;
    logic [3:0] count;
  } escape_t;

  localparam logic signed [63:0] ESCAPE_BOUND = 64'sd4 <<< (2 * FRAC_BITS);
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 70;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_point_re = '0;
  logic signed [15:0] in_point_im = '0;
  logic [2:0]         in_start_layer = '0;
  logic               out_valid;
  logic [2:0]         out_escape_layer;
  logic [3:0]         out_escape_count;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [31:0]        cfg_wdata = '0;

  layered_julia_escape_pixel_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_re(in_point_re), .in_point_im(in_point_im),
    .in_start_layer(in_start_layer),
    .out_valid(out_valid), .out_escape_layer(out_escape_layer),
    .out_escape_count(out_escape_count),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  logic [31:0] layer_const [1:LAYERS-1];
  pixel_t      pixel_q [$];
  escape_t     escape_q [$];
  pixel_t      cur_pixel;
  int          n_issued = 0;
  int          n_results = 0;
  int          mismatches = 0;
  int          gap = 0;
  bit          steady = 1'b0;
  int          stall_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic escape_t predict_escape(pixel_t px);
    escape_t     r;
    logic [31:0] x, y, x1, y1, cre, cim, c;
    logic signed [31:0] diff, prod, mag;
    logic signed [63:0] mag_wide;
    int top;
    r.layer = '0;
    r.count = '0;
    top = (px.layer > LAYERS - 1) ? LAYERS - 1 : px.layer;
    for (int l = top; l >= 1; l--) begin
      c   = layer_const[l];
      cre = {{16{c[15]}}, c[15:0]};
      cim = {{16{c[31]}}, c[31:16]};
      x   = {{16{px.re[15]}}, px.re} << (LAYERS - 1 - l);
      y   = {{16{px.im[15]}}, px.im} << (LAYERS - 1 - l);
      for (int k = 0; k < 2 * l; k++) begin
        diff = x * x - y * y;
        diff = diff >>> FRAC_BITS;
        x1   = diff + cre;
        prod = x * y;
        prod = prod >>> (FRAC_BITS - 1);
        y1   = prod + cim;
        mag  = x1 * x1 + y1 * y1;
        mag_wide = mag;
        x = x1;
        y = y1;
        if (mag_wide > ESCAPE_BOUND) begin
          r.layer = l[2:0];
          r.count = k[3:0];
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pack_c(input int re, input int im);
    return {im[15:0], re[15:0]};
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    int s;
    case ($urandom_range(0, 3))
      0: begin
        px.re = 16'($urandom());
        px.im = 16'($urandom());
      end
      3: begin
        px.re = 16'($urandom_range(0, 2047) - 1024);
        px.im = 16'($urandom_range(0, 2047) - 1024);
      end
      default: begin
        px.re = 16'($urandom_range(0, 16383) - 8192);
        px.im = 16'($urandom_range(0, 16383) - 8192);
      end
    endcase
    s = $urandom_range(0, 9);
    px.layer = (s > 7) ? 3'd7 : s[2:0];
    return px;
  endfunction

  task automatic queue_pixel(input int re, input int im, input int layer);
    pixel_t px;
    px.re = 16'(re);
    px.im = 16'(im);
    px.layer = 3'(layer);
    pixel_q.push_back(px);
    n_issued++;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      pixel_q.push_back(rand_pixel());
      n_issued++;
    end
  endtask

  task automatic write_const(input layer_reg_t r, input logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= v;
    if (r != C_SPARE) layer_const[int'(r) + 1] = v;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (n_results != n_issued) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    logic launch;
    launch = start;
    if (!rst_n) begin
      launch = 1'b0;
    end else begin
      if (start && !busy) begin
        escape_q.push_back(predict_escape(cur_pixel));
        launch = 1'b0;
        if ($urandom_range(0, 39) == 0) steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 5);
      end
      if (!launch && pixel_q.size() != 0) begin
        if (gap != 0) begin
          gap--;
        end else begin
          cur_pixel = pixel_q.pop_front();
          in_point_re    <= cur_pixel.re;
          in_point_im    <= cur_pixel.im;
          in_start_layer <= cur_pixel.layer;
          launch = 1'b1;
        end
      end
    end
    start <= launch;
  end

  // monitor
  always @(posedge clk) begin
    escape_t want;
    if (rst_n && out_valid) begin
      if (escape_q.size() == 0) begin
        $display("%0t: unexpected item: layer %0d count %0d", $realtime,
                 out_escape_layer, out_escape_count);
        mismatches++;
      end else begin
        want = escape_q.pop_front();
        n_results++;
        if (out_escape_layer !== want.layer) begin
          $display("%0t: escape_layer expected %0d actual %0d", $realtime,
                   want.layer, out_escape_layer);
          mismatches++;
        end
        if (out_escape_count !== want.count) begin
          $display("%0t: escape_count expected %0d actual %0d", $realtime,
                   want.count, out_escape_count);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] edge_c [7];
    int typ_re [7];
    int typ_im [7];
    edge_c = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_7FFF, 32'h8000_8000,
               32'h7FFF_8000, 32'h8000_7FFF, 32'h0001_0001};
    typ_re = '{-3277, -2867, -1638, 1167, -3420, -2874, 1843};
    typ_im = '{639, 2212, 2458, 41, -951, -1574, 585};
    for (int i = 1; i < LAYERS; i++) layer_const[i] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // constants at reset value: start layer zero, zero orbit, extreme points
    queue_pixel(0, 0, 0);
    queue_pixel(0, 0, 7);
    queue_pixel(32767, 32767, 7);
    queue_pixel(-32768, -32768, 7);
    queue_pixel(-32768, 32767, 1);
    queue_pixel(32767, -32768, 3);
    queue_pixel(4096, 0, 7);
    drain();

    // typical Julia constants, each start layer
    for (int i = 0; i < 7; i++) write_const(layer_reg_t'(i), pack_c(typ_re[i], typ_im[i]));
    end_writes();
    for (int l = 1; l <= 7; l++) queue_pixel(2048, 1024, l);
    queue_pixel(0, 0, 7);
    queue_pixel(0, 0, 0);
    queue_pixel(8192, 8192, 7);
    queue_pixel(-32768, 0, 7);
    queue_pixel(1, -1, 7);
    queue_pixel(-1, 1, 2);
    queue_random(360);
    drain();

    // extreme constants; the spare index must not disturb anything
    for (int i = 0; i < 7; i++) write_const(layer_reg_t'(i), edge_c[i]);
    write_const(C_SPARE, $urandom());
    end_writes();
    queue_random(360);
    drain();

    for (int p = 0; p < 2; p++) begin
      for (int i = 0; i < 7; i++)
        write_const(layer_reg_t'(i), pack_c($urandom_range(0, 16383) - 8192,
                                            $urandom_range(0, 16383) - 8192));
      end_writes();
      queue_random(360);
      drain();
    end

    for (int i = 0; i < 7; i++) write_const(layer_reg_t'(i), $urandom());
    end_writes();
    queue_random(360);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && escape_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
